// ----- hw/rtl/dhsd_pkg.sv -----
// Shared constants and types for the detector hit stream decoder.
package dhsd_pkg;

  localparam int FEE_COUNT_DEF = 16;
  localparam int FEE_W         = 4;
  localparam int WORD_W        = 32;
  localparam int STAMP_W       = 40;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 112;

  localparam logic [WORD_W-1:0] HDR_MASK = 32'hff00ffff;
  localparam logic [WORD_W-1:0] HDR_CODE = 32'had00cade;

  // Write request to the per-channel stamp store.
  typedef struct packed {
    logic               cur_we;
    logic               first_we;
    logic [STAMP_W-1:0] wdata;
  } mem_wr_t;

  // Beat leaving the parse stage toward the result register.
  typedef struct packed {
    logic [FEE_W-1:0]   fee;
    logic [STAMP_W-1:0] stamp;
    logic [WORD_W-1:0]  word;
  } hit_t;

  typedef struct packed {
    logic fire;  // parse stage retires its beat this cycle
    logic emit;  // and hands a hit to the result register
  } pars_ctl_t;

endpackage

// ----- hw/rtl/dhsd_stamp_mem.sv -----
// Per-channel stamp store: current and first stamps, registered read with write forwarding.
module dhsd_stamp_mem #(
  parameter int DEPTH = dhsd_pkg::FEE_COUNT_DEF,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  input  dhsd_pkg::mem_wr_t            wr,
  input  logic [AW-1:0]                wr_addr,
  output logic [dhsd_pkg::STAMP_W-1:0] rd_cur,
  output logic [dhsd_pkg::STAMP_W-1:0] rd_first
);
  import dhsd_pkg::*;

  logic [STAMP_W-1:0] cur_mem   [DEPTH];
  logic [STAMP_W-1:0] first_mem [DEPTH];
  logic [STAMP_W-1:0] rd_cur_r;
  logic [STAMP_W-1:0] rd_first_r;
  logic               same_addr;

  assign same_addr = (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.cur_we) begin
      cur_mem[wr_addr] <= wr.wdata;
    end
    if (wr.first_we) begin
      first_mem[wr_addr] <= wr.wdata;
    end
    // forward a write landing in the same cycle on the same channel
    if (rd_en) begin
      rd_cur_r   <= (wr.cur_we && same_addr) ? wr.wdata : cur_mem[rd_addr];
      rd_first_r <= (wr.first_we && same_addr) ? wr.wdata : first_mem[rd_addr];
    end
  end

  assign rd_cur   = rd_cur_r;
  assign rd_first = rd_first_r;

endmodule

// ----- hw/rtl/dhsd_parser.sv -----
// Per-channel parse state and the decision logic of the parse stage.
module dhsd_parser #(
  parameter int FEE_COUNT = dhsd_pkg::FEE_COUNT_DEF,
  parameter int AW        = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  logic                         s1_action,
  input  logic [dhsd_pkg::FEE_W-1:0]   s1_fee,
  input  logic [dhsd_pkg::WORD_W-1:0]  s1_word,
  input  logic [dhsd_pkg::STAMP_W-1:0] rd_cur,
  input  logic [dhsd_pkg::STAMP_W-1:0] rd_first,
  input  logic                         out_free,
  output dhsd_pkg::pars_ctl_t          ctl,
  output dhsd_pkg::hit_t               hit,
  output dhsd_pkg::mem_wr_t            mem_wr,
  output logic [AW-1:0]                wr_addr
);
  import dhsd_pkg::*;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_STAMP,
    PH_HITS,
    PH_STOP
  } phase_t;

  phase_t             phase_r     [FEE_COUNT];
  logic               first_vld_r [FEE_COUNT];

  logic [AW-1:0]      idx;
  logic               fee_ok;
  logic               is_hdr;
  phase_t             cur_phase;
  logic               cur_first_vld;
  phase_t             phase_nxt;
  logic               set_first;
  logic               emit_req;
  logic               fire;
  logic [STAMP_W-1:0] stamp;
  mem_wr_t            wr_req;

  assign idx           = AW'(s1_fee);
  assign fee_ok        = (32'(s1_fee) < 32'(FEE_COUNT));
  assign cur_phase     = fee_ok ? phase_r[idx] : PH_SEEK;
  assign cur_first_vld = fee_ok ? first_vld_r[idx] : 1'b0;
  assign is_hdr        = ((s1_word & HDR_MASK) == HDR_CODE);
  // stamp word: low half is bits 31:16, high half is bits 15:0
  assign stamp         = {rd_cur[STAMP_W-1:WORD_W], s1_word[15:0], s1_word[31:16]};

  always_comb begin
    phase_nxt = cur_phase;
    set_first = 1'b0;
    emit_req  = 1'b0;
    wr_req    = '0;
    if (!s1_action && fee_ok) begin
      unique case (cur_phase) inside
        PH_SEEK, PH_HITS: begin
          if (is_hdr) begin
            wr_req.cur_we = 1'b1;
            wr_req.wdata  = {s1_word[23:16], {WORD_W{1'b0}}};
            phase_nxt     = PH_STAMP;
          end else if (cur_phase == PH_HITS) begin
            emit_req = 1'b1;
          end
        end
        PH_STAMP: begin
          if (cur_first_vld && (stamp != rd_first)) begin
            phase_nxt = PH_STOP;
          end else begin
            wr_req.cur_we = 1'b1;
            wr_req.wdata  = stamp;
            phase_nxt     = PH_HITS;
            if (!cur_first_vld && (stamp != '0)) begin
              wr_req.first_we = 1'b1;
              set_first       = 1'b1;
            end
          end
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = cur_phase;
        end
      endcase
    end
  end

  // retire unless a hit has nowhere to go
  assign fire = s1_valid && (!emit_req || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FEE_COUNT; k++) begin
        phase_r[k]     <= PH_SEEK;
        first_vld_r[k] <= 1'b0;
      end
    end else if (fire) begin
      if (s1_action) begin
        for (int k = 0; k < FEE_COUNT; k++) begin
          phase_r[k]     <= PH_SEEK;
          first_vld_r[k] <= 1'b0;
        end
      end else if (fee_ok) begin
        phase_r[idx] <= phase_nxt;
        if (set_first) begin
          first_vld_r[idx] <= 1'b1;
        end
      end
    end
  end

  assign ctl.fire        = fire;
  assign ctl.emit        = fire && emit_req;
  assign hit.fee         = s1_fee;
  assign hit.stamp       = rd_cur;
  assign hit.word        = s1_word;
  assign mem_wr.cur_we   = fire && wr_req.cur_we;
  assign mem_wr.first_we = fire && wr_req.first_we;
  assign mem_wr.wdata    = wr_req.wdata;
  assign wr_addr         = idx;

endmodule

// ----- hw/rtl/detector_hit_stream_decoder.sv -----
// Top level of the detector hit stream decoder: input stage, parser, stamp store, result register.
//
// Decodes 32-bit readout words, each tagged with a front-end channel, keeping
// one parse context per channel. Per channel, words are skipped until a header
// (word & 0xff00ffff == 0xad00cade); the header supplies stamp bits 39:32, the
// next word supplies bits 31:0 (low half -> 31:16, high half -> 15:0), and each
// following non-header word yields one hit beat carrying that stamp. A stamp
// that differs from the first nonzero stamp of the event stops the channel; a
// beat with in_tuser high is an event boundary that returns every channel to
// its reset context and yields nothing. Words for channels at or above
// FEE_COUNT are dropped. Throughput is one input beat per clock unless a hit
// is held at the parse stage; a hit moves from the input stage into the
// result register on out_tdata; out_tready takes it. The pace is set by the
// parse stage: the stamp store is read while a beat is registered and written
// when it retires, with same-channel writes forwarded into the read, so
// back-to-back beats on one channel cost no bubble. The input side keeps
// taking beats while a hit waits on the output register; it stalls only when
// the parse stage holds a hit that cannot move. No clearing pass is needed
// after reset: per-channel phase and first-stamp-valid flags sit in
// flip-flops and gate the stamp store.
module detector_hit_stream_decoder #(
  parameter int FEE_COUNT = dhsd_pkg::FEE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] fee_channel, [35:4] data_word, [39:36] zero
  input  logic [dhsd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] action: 1 = event boundary
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] hit_fee, [43:4] hit_stamp, [50:44] chan_num, [56:51] chip_id,
  // [59:57] adc_value, [66:60] chip_crossing, [67] chip_full,
  // [68] readout_full, [74:69] amplitude, [106:75] raw_hit_word, [111:107] zero
  output logic [dhsd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dhsd_pkg::*;

  localparam int AW = (FEE_COUNT > 1) ? $clog2(FEE_COUNT) : 1;

  // input stage
  logic               s1_valid_r;
  logic               s1_action_r;
  logic [FEE_W-1:0]   s1_fee_r;
  logic [WORD_W-1:0]  s1_word_r;

  // result register
  logic               out_valid_r;
  hit_t               out_hit_r;

  logic               accept;
  logic               out_free;
  pars_ctl_t          ctl;
  hit_t               hit;
  mem_wr_t            mem_wr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [STAMP_W-1:0] rd_cur;
  logic [STAMP_W-1:0] rd_first;
  logic [WORD_W-1:0]  w;

  // take a beat whenever the input stage is empty or retires this cycle
  assign in_tready = !s1_valid_r || ctl.fire;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign rd_addr   = AW'(in_tdata[FEE_W-1:0]);

  dhsd_stamp_mem #(
    .DEPTH (FEE_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr       (mem_wr),
    .wr_addr  (wr_addr),
    .rd_cur   (rd_cur),
    .rd_first (rd_first)
  );

  dhsd_parser #(
    .FEE_COUNT (FEE_COUNT),
    .AW        (AW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_action (s1_action_r),
    .s1_fee    (s1_fee_r),
    .s1_word   (s1_word_r),
    .rd_cur    (rd_cur),
    .rd_first  (rd_first),
    .out_free  (out_free),
    .ctl       (ctl),
    .hit       (hit),
    .mem_wr    (mem_wr),
    .wr_addr   (wr_addr)
  );

  // input stage: load on accept, drop once retired
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (ctl.fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_tuser;
      s1_fee_r    <= in_tdata[FEE_W-1:0];
      s1_word_r   <= in_tdata[FEE_W +: WORD_W];
    end
  end

  // result register: load a new hit, or clear once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_hit_r <= hit;
    end
  end

  // unpack the hit word into its fields
  assign w          = out_hit_r.word;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, w, w[14:9], w[8], w[7], w[6:0], w[31:29], w[28:23],
                       w[22:16], out_hit_r.stamp, out_hit_r.fee};

`ifndef SYNTHESIS
  a_emit_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (s1_valid_r && !s1_action_r))
    else $error("hit emitted without a data beat in the input stage");

  a_no_s1_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_valid_r) |-> ctl.fire)
    else $error("input stage overwritten before it retired");

  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while holding an untaken beat");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r)
    else $error("emitted hit not presented on the output");
`endif

endmodule
